FILE: sv/dws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg
// Types and constants shared by the delimited word splitter modules.
// ----------------------------------------------------------------------------
package dws_pkg;

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 4;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              end_of_string;
  } dws_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               has_char;
    logic [INDEX_W-1:0] word_index;
    logic               word_last;
    logic               list_end;
  } dws_out_t;

  // readout job handed from the input side to the readout side
  typedef struct packed {
    logic               start;
    logic [INDEX_W-1:0] idx;
    logic               list_end;
  } dws_job_t;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LIMIT = 3'd4;

  localparam logic [CHAR_W-1:0]  STOP_A_RST     = 8'd32;
  localparam logic [CHAR_W-1:0]  STOP_B_RST     = 8'd44;
  localparam logic [CHAR_W-1:0]  STOP_C_RST     = 8'd46;
  localparam logic [CHAR_W-1:0]  STOP_D_RST     = 8'd10;
  localparam logic [INDEX_W-1:0] WORD_LIMIT_RST = 4'd10;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

endpackage

FILE: sv/dws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_ctrl
// Configuration registers and per-character word state; writes characters
// into the word store and starts readout jobs.
// ----------------------------------------------------------------------------
module dws_ctrl #(
  parameter int MAX_WORD_LEN = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_fire,
  input  dws_pkg::dws_in_t                      in_data,
  input  logic                                  cfg_fire,
  input  logic [dws_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dws_pkg::CHAR_W-1:0]            cfg_data,
  output logic                                  wr_en,
  output logic [$clog2(MAX_WORD_LEN)-1:0]       wr_addr,
  output logic [dws_pkg::CHAR_W-1:0]            wr_data,
  output dws_pkg::dws_job_t                     job,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]     job_len
);
  import dws_pkg::*;

  localparam int AW = $clog2(MAX_WORD_LEN);
  localparam int LW = $clog2(MAX_WORD_LEN + 1);

  logic [CHAR_W-1:0]  stop_a_r, stop_b_r, stop_c_r, stop_d_r;
  logic [INDEX_W-1:0] limit_r;
  logic [LW-1:0]      len_r, len_nxt;
  logic [INDEX_W-1:0] count_r, count_nxt;
  logic               limited_r, limited_nxt;

  logic [CHAR_W-1:0]  c;
  logic [CHAR_W-1:0]  lc;
  logic               is_stop;
  logic               store;
  logic [LW-1:0]      len_a;
  logic               stop_flush;
  logic               eos_flush;
  logic               flush;
  logic               marker;
  logic [INDEX_W-1:0] count_p1;
  logic               lim_hit;
  logic               eos;

  always_comb begin
    c        = in_data.in_char;
    eos      = in_data.end_of_string;
    is_stop  = (c == stop_a_r) || (c == stop_b_r) || (c == stop_c_r) || (c == stop_d_r);
    lc       = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
    store    = !limited_r && !is_stop && (len_r != LW'(MAX_WORD_LEN));
    len_a    = store ? len_r + LW'(1) : len_r;
    count_p1 = count_r + INDEX_W'(1);
    lim_hit  = count_p1 >= limit_r;
    stop_flush = !limited_r && is_stop && (len_r != '0);
    eos_flush  = eos && !limited_r && !stop_flush && (len_a != '0);
    flush      = stop_flush || eos_flush;
    marker     = eos && !flush && !limited_r;

    wr_en   = in_fire && store;
    wr_addr = len_r[AW-1:0];
    wr_data = lc;

    job.start    = in_fire && (flush || marker);
    job.idx      = count_r;
    job.list_end = eos || lim_hit;
    job_len      = marker ? '0 : len_a;

    len_nxt     = len_r;
    count_nxt   = count_r;
    limited_nxt = limited_r;
    if (in_fire) begin
      if (eos) begin
        len_nxt     = '0;
        count_nxt   = '0;
        limited_nxt = 1'b0;
      end else if (flush) begin
        len_nxt     = '0;
        count_nxt   = count_p1;
        limited_nxt = lim_hit;
      end else begin
        len_nxt = len_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_a_r  <= STOP_A_RST;
      stop_b_r  <= STOP_B_RST;
      stop_c_r  <= STOP_C_RST;
      stop_d_r  <= STOP_D_RST;
      limit_r   <= WORD_LIMIT_RST;
      len_r     <= '0;
      count_r   <= '0;
      limited_r <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      count_r   <= count_nxt;
      limited_r <= limited_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_STOP_A:     stop_a_r <= cfg_data;
          CFG_STOP_B:     stop_b_r <= cfg_data;
          CFG_STOP_C:     stop_c_r <= cfg_data;
          CFG_STOP_D:     stop_d_r <= cfg_data;
          CFG_WORD_LIMIT: limit_r  <= cfg_data[INDEX_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/dws_rdout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_rdout
// Reads a finished word out of the word store one character per cycle while
// out_ready holds, drives the result register and sends the empty end marker.
// ----------------------------------------------------------------------------
module dws_rdout #(
  parameter int MAX_WORD_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dws_pkg::dws_job_t                 job,
  input  logic [$clog2(MAX_WORD_LEN+1)-1:0] job_len,
  output logic                              busy,
  output logic                              rd_en,
  output logic [$clog2(MAX_WORD_LEN)-1:0]   rd_addr,
  input  logic [dws_pkg::CHAR_W-1:0]        rd_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dws_pkg::dws_out_t                 out_data
);
  import dws_pkg::*;

  localparam int AW = $clog2(MAX_WORD_LEN);
  localparam int LW = $clog2(MAX_WORD_LEN + 1);

  logic [LW-1:0]      rem_r, rem_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic               lend_r, lend_nxt;
  logic               qv_r, qv_nxt;
  logic               qlast_r, qlast_nxt;
  logic               marker_r, marker_nxt;
  logic               ov_r, ov_nxt;
  dws_out_t           out_r, out_nxt;

  logic mv;
  logic take_q;
  logic take_marker;
  logic issue;

  always_comb begin
    mv          = !ov_r || out_ready;
    take_q      = qv_r && mv;
    take_marker = marker_r && mv;
    issue       = (rem_r != '0) && (!qv_r || take_q);

    rem_nxt    = rem_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    lend_nxt   = lend_r;
    qv_nxt     = qv_r;
    qlast_nxt  = qlast_r;
    marker_nxt = marker_r;
    ov_nxt     = ov_r;
    out_nxt    = out_r;

    if (job.start) begin
      idx_nxt  = job.idx;
      lend_nxt = job.list_end;
      ptr_nxt  = '0;
      if (job_len == '0) begin
        marker_nxt = 1'b1;
      end else begin
        rem_nxt = job_len;
      end
    end

    if (issue) begin
      rem_nxt   = rem_r - LW'(1);
      ptr_nxt   = ptr_r + AW'(1);
      qv_nxt    = 1'b1;
      qlast_nxt = (rem_r == LW'(1));
    end else if (take_q) begin
      qv_nxt = 1'b0;
    end

    if (take_q) begin
      ov_nxt             = 1'b1;
      out_nxt.out_char   = rd_data;
      out_nxt.has_char   = 1'b1;
      out_nxt.word_index = idx_r;
      out_nxt.word_last  = qlast_r;
      out_nxt.list_end   = qlast_r && lend_r;
    end else if (take_marker) begin
      ov_nxt     = 1'b1;
      marker_nxt = 1'b0;
      out_nxt    = '{out_char: '0, has_char: 1'b0, word_index: '0,
                     word_last: 1'b0, list_end: 1'b1};
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      qv_r     <= 1'b0;
      marker_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      qv_r     <= qv_nxt;
      marker_r <= marker_nxt;
      ov_r     <= ov_nxt;
    end
    ptr_r   <= ptr_nxt;
    idx_r   <= idx_nxt;
    lend_r  <= lend_nxt;
    qlast_r <= qlast_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (rem_r != '0) || qv_r || marker_r;
  assign rd_en     = issue;
  assign rd_addr   = ptr_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

FILE: sv/delimited_word_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_word_splitter
// Splits a character stream into lowercased words at four stop characters.
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_ready    dws_in_t  (char, end of string)
//   out_     out        out_valid / out_ready  dws_out_t (word character)
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a non-stop character is stored unless the limit is hit or the word is full
// a word of n characters is read out at one per cycle, while out_ready holds,
// through the store's read port; new requests wait while it drains
// end of string with nothing to send and no limit hit gives one marker result
// reset needs no clearing pass: only written store entries are ever read
// output stalls back up through the read pipeline into in_ready
// ----------------------------------------------------------------------------
module delimited_word_splitter #(
  parameter int MAX_WORD_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dws_pkg::dws_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dws_pkg::dws_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dws_pkg::CHAR_W-1:0]    cfg_data
);
  import dws_pkg::*;

  localparam int AW = $clog2(MAX_WORD_LEN);
  localparam int LW = $clog2(MAX_WORD_LEN + 1);

  logic              busy;
  logic              in_fire;
  logic              cfg_fire;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] rd_data;
  dws_job_t          job;
  logic [LW-1:0]     job_len;

  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  dws_ctrl #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job       (job),
    .job_len   (job_len)
  );

  dws_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_WORD_LEN)
  ) u_word_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dws_rdout #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_rdout (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_len   (job_len),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/delimited_word_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_word_splitter_tb
// Self-checking bench for the word splitter. A short stimulus table covers
// field extremes, empty words, the end marker, limit hits and stop character
// zero. Random strings then run under several stop/limit settings and
// flow-control mixes. A behavioral tokenizer inside the bench predicts the
// output characters, except where a table row gives its own expected result.
// Outputs are compared in order against the expected results.
// ----------------------------------------------------------------------------
module delimited_word_splitter_tb;
  import dws_pkg::*;

  localparam int MAX_LEN       = 64;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_REQS    = 75;
  localparam int LIMIT_NS      = 3_000_000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CHAR_W-1:0]    val;
    logic                 eos;
    logic                 typed;
    logic                 one;
    dws_out_t             res;
  } plan_row_t;

  localparam dws_out_t MARKER = '{8'h00, 1'b0, 4'd0, 1'b0, 1'b1};
  localparam dws_out_t NONE   = '0;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  dws_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  dws_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CHAR_W-1:0]    cfg_data;

  // tokenizer shadow: settings and word state
  logic [CHAR_W-1:0]  stop_a, stop_b, stop_c, stop_d;
  logic [INDEX_W-1:0] word_limit_q;
  logic [CHAR_W-1:0]  word_buf [MAX_LEN];
  int                 word_len;
  logic [INDEX_W-1:0] word_num;
  bit                 limit_hit;

  dws_out_t step_buf [MAX_LEN];
  int       step_n;
  dws_out_t pending_chars [$];

  int err_cnt, req_cnt, live_cnt, res_cnt, cfg_cnt;
  int in_idle_pct, out_stall_pct;

  plan_row_t plan [30] = '{
    '{ROW_REQ, '0, 8'h20, 1'b1, 1'b1, 1'b1, MARKER},
    '{ROW_REQ, '0, 8'h41, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h5A, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h40, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h5B, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h2C, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h00, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'hFF, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h61, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h7A, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h2E, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h2E, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h51, 1'b1, 1'b1, 1'b1, '{8'h71, 1'b1, 4'd2, 1'b1, 1'b1}},
    '{ROW_REQ, '0, 8'h0A, 1'b1, 1'b1, 1'b1, MARKER},
    '{ROW_REQ, '0, 8'h4D, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h20, 1'b1, 1'b1, 1'b1, '{8'h6D, 1'b1, 4'd0, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_WORD_LIMIT, 8'h00, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CFG, CFG_STOP_A, 8'h00, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h42, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h00, 1'b0, 1'b1, 1'b1, '{8'h62, 1'b1, 4'd0, 1'b1, 1'b1}},
    '{ROW_REQ, '0, 8'h43, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h00, 1'b1, 1'b1, 1'b0, NONE},
    '{ROW_CFG, CFG_WORD_LIMIT, 8'h02, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CFG, CFG_STOP_A, 8'h20, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h78, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h20, 1'b0, 1'b1, 1'b1, '{8'h78, 1'b1, 4'd0, 1'b1, 1'b0}},
    '{ROW_REQ, '0, 8'h59, 1'b0, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'h2C, 1'b0, 1'b1, 1'b1, '{8'h79, 1'b1, 4'd1, 1'b1, 1'b1}},
    '{ROW_REQ, '0, 8'h4B, 1'b1, 1'b1, 1'b0, NONE},
    '{ROW_REQ, '0, 8'hFF, 1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 4'd0, 1'b1, 1'b1}}
  };

  delimited_word_splitter #(.MAX_WORD_LEN(MAX_LEN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_stop(input logic [CHAR_W-1:0] c);
    return c == stop_a || c == stop_b || c == stop_c || c == stop_d;
  endfunction

  function automatic void emit_word();
    for (int i = 0; i < word_len; i++) begin
      step_buf[step_n] = '{word_buf[i], 1'b1, word_num, (i == word_len - 1), 1'b0};
      step_n++;
    end
    word_len = 0;
    word_num = word_num + 4'd1;
    if (word_num >= word_limit_q) begin
      limit_hit = 1'b1;
      step_buf[step_n-1].list_end = 1'b1;
    end
  endfunction

  function automatic void tokenize_step(input logic [CHAR_W-1:0] ch, input logic eos,
                                        output bit live);
    logic [CHAR_W-1:0] c;
    bit                was;
    c      = ch;
    was    = limit_hit;
    step_n = 0;
    if (!was) begin
      if (is_stop(c)) begin
        if (word_len > 0) emit_word();
      end else if (word_len < MAX_LEN) begin
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
        word_buf[word_len] = c;
        word_len++;
      end
    end
    if (eos) begin
      if (!limit_hit && word_len > 0) emit_word();
      if (step_n > 0) begin
        step_buf[step_n-1].list_end = 1'b1;
      end else if (!was) begin
        step_buf[0] = MARKER;
        step_n      = 1;
      end
      word_len  = 0;
      word_num  = '0;
      limit_hit = 1'b0;
    end
    live = !was || eos;
  endfunction

  function automatic logic [CHAR_W-1:0] word_char();
    logic [CHAR_W-1:0] c;
    do begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c = CHAR_W'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
        4, 5, 6:    c = CHAR_W'($urandom_range(8'h61, 8'h7A));
        default:    c = CHAR_W'($urandom_range(0, 255));
      endcase
    end while (is_stop(c));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] stop_char();
    case ($urandom_range(0, 3))
      0:       return stop_a;
      1:       return stop_b;
      2:       return stop_c;
      default: return stop_d;
    endcase
  endfunction

  task automatic send_req(input logic [CHAR_W-1:0] ch, input logic eos,
                          input bit typed = 1'b0, input bit one = 1'b0,
                          input dws_out_t tres = '0);
    bit live;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch, eos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_step(ch, eos, live);
    req_cnt++;
    if (live) live_cnt++;
    if (typed) begin
      if (one) pending_chars.push_back(tres);
    end else begin
      for (int i = 0; i < step_n; i++) pending_chars.push_back(step_buf[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STOP_A:     stop_a = val;
      CFG_STOP_B:     stop_b = val;
      CFG_STOP_C:     stop_c = val;
      CFG_STOP_D:     stop_d = val;
      CFG_WORD_LIMIT: word_limit_q = val[INDEX_W-1:0];
      default: ;
    endcase
    cfg_cnt++;
    @(posedge clk);
  endtask

  task automatic send_string(input bit force_long);
    int n_words;
    int len;
    n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
    for (int w = 0; w < n_words; w++) begin
      if (force_long && w == 0) len = 66;
      else if ($urandom_range(0, 49) == 0) len = $urandom_range(60, 70);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 30);
      else len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_req(word_char(), 1'b0);
      if (w < n_words - 1 || $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 2)) send_req(stop_char(), 1'b0);
    end
    send_req(($urandom_range(0, 1) == 1) ? word_char() : stop_char(), 1'b1);
  endtask

  task automatic run_phase(input int p);
    int req0;
    bit paused;
    quiesce();
    case (p)
      0: begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_reg(CFG_WORD_LIMIT, 8'h0F);
        write_reg(CFG_STOP_B, 8'h3B);
      end
      1: begin
        in_idle_pct   = 81;
        out_stall_pct = 0;
        write_reg(CFG_STOP_A, 8'h00);
        write_reg(CFG_STOP_B, 8'hFF);
        write_reg(CFG_STOP_C, 8'h45);
        write_reg(CFG_WORD_LIMIT, 8'hF1);
      end
      2: begin
        in_idle_pct   = 0;
        out_stall_pct = 81;
        write_reg(CFG_STOP_D, CHAR_W'($urandom_range(0, 255)));
        write_reg(CFG_STOP_C, 8'h2D);
        write_reg(CFG_WORD_LIMIT, 8'h10);
        write_reg(3'd7, 8'hAA);
      end
      default: begin
        in_idle_pct   = 25;
        out_stall_pct = 25;
        write_reg(CFG_STOP_A, STOP_A_RST);
        write_reg(CFG_STOP_B, STOP_B_RST);
        write_reg(CFG_STOP_C, STOP_C_RST);
        write_reg(CFG_STOP_D, STOP_D_RST);
        write_reg(CFG_WORD_LIMIT, 8'h03);
        write_reg(3'd5, 8'h55);
      end
    endcase
    req0   = req_cnt;
    paused = 1'b0;
    if (p == 0) send_string(1'b1);
    while (req_cnt - req0 < PHASE_REQS) begin
      // once in phase 1, the sender holds off until the output has drained
      if (p == 1 && !paused && req_cnt - req0 >= PHASE_REQS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 15)
        send_req(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      else
        send_string(1'b0);
    end
  endtask

  always begin : out_side
    bit       fire;
    dws_out_t got;
    dws_out_t want;
    @(posedge clk);
    fire = rst_n && out_valid && out_ready;
    got  = out_data;
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    #1;
    if (fire) begin
      if (pending_chars.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result char=%h has=%b idx=%0d last=%b end=%b", $time,
                 got.out_char, got.has_char, got.word_index, got.word_last, got.list_end);
      end else begin
        want = pending_chars.pop_front();
        res_cnt++;
        if (got.out_char !== want.out_char || got.has_char !== want.has_char ||
            got.word_index !== want.word_index || got.word_last !== want.word_last ||
            got.list_end !== want.list_end) begin
          err_cnt++;
          $display("%0t: mismatch expected char=%h has=%b idx=%0d last=%b end=%b", $time,
                   want.out_char, want.has_char, want.word_index, want.word_last,
                   want.list_end);
          $display("%0t:          actual   char=%h has=%b idx=%0d last=%b end=%b", $time,
                   got.out_char, got.has_char, got.word_index, got.word_last, got.list_end);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    stop_a        = STOP_A_RST;
    stop_b        = STOP_B_RST;
    stop_c        = STOP_C_RST;
    stop_d        = STOP_D_RST;
    word_limit_q  = WORD_LIMIT_RST;
    word_len      = 0;
    word_num      = '0;
    limit_hit     = 1'b0;
    err_cnt       = 0;
    req_cnt       = 0;
    live_cnt      = 0;
    res_cnt       = 0;
    cfg_cnt       = 0;
    in_idle_pct   = 30;
    out_stall_pct = 30;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        quiesce();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        send_req(plan[r].val, plan[r].eos, plan[r].typed, plan[r].one, plan[r].res);
      end
    end

    for (int p = 0; p < 4; p++) run_phase(p);

    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("sent %0d requests (%0d not ignored), checked %0d results, %0d register writes",
             req_cnt, live_cnt, res_cnt, cfg_cnt);
    $display("covered reset and extreme stop/limit settings under four stall mixes");
    if (err_cnt == 0) begin
      $display("delimited_word_splitter_tb OK");
    end else begin
      $display("delimited_word_splitter_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("delimited_word_splitter_tb NOT OK");
    $finish;
  end

endmodule
